// ===== sv/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants and types for the shortest path engine.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int MAX_NODES   = 64;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int NCNT_W      = NODE_W + 1;
    localparam int MAX_EDGES   = 2048;
    localparam int EADDR_W     = $clog2(MAX_EDGES);
    localparam int ECNT_W      = EADDR_W + 1;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_W      = 30;
    localparam int EDGE_W      = 2 * NODE_W + WEIGHT_BITS;

    localparam logic [DIST_W-1:0] UNREACHED = 30'd1000000000;

    localparam logic       CMD_ADD   = 1'b0;
    localparam logic       CMD_SOLVE = 1'b1;
    localparam logic       REG_NODE_COUNT  = 1'b0;
    localparam logic       REG_SOURCE_NODE = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_INIT     = 9'b000000010,
        ST_SCAN     = 9'b000000100,
        ST_MIN      = 9'b000001000,
        ST_RLX_RD   = 9'b000010000,
        ST_RLX_EDGE = 9'b000100000,
        ST_RLX_DIST = 9'b001000000,
        ST_EMIT_RD  = 9'b010000000,
        ST_EMIT_LD  = 9'b100000000
    } state_t;

endpackage

// ===== sv/spd_ram.sv =====
// ----------------------------------------------------------------------------
// spd_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module spd_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/shortest_path_dijkstra.sv =====
// Add-edge transactions are taken one per cycle while the engine is idle and produce no result.
// A solve reads the edge and distance RAMs, each through its single read port.
// Each result is read from the distance RAM in ST_EMIT_RD and registered in
// ST_EMIT_LD, which waits while the output is stalled.
// Reset clears the edge count, the error flag and the control state; the RAMs
// need no clearing pass.
// ----------------------------------------------------------------------------
// shortest_path_dijkstra
// Dijkstra single-source shortest path engine with an edge RAM and a
// distance RAM, emitting one distance per node after each solve.
// ----------------------------------------------------------------------------
module shortest_path_dijkstra
    import spd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // node_a, node_b, weight, zero pad
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // node, distance, zero pad
    output logic [1:0]  m_axis_tuser,   // reachable, input_error
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    state_t              state_reg, state_next;
    logic [NCNT_W-1:0]   node_count_reg;
    logic [NODE_W-1:0]   source_reg;
    logic [ECNT_W-1:0]   edge_count_reg;
    logic                dropped_reg;
    logic                err_reg;
    logic [ECNT_W-1:0]   k_reg;
    logic [NCNT_W-1:0]   i_reg;
    logic                rd_v_reg;
    logic [NODE_W-1:0]   rd_idx_reg;
    logic [DIST_W-1:0]   best_reg;
    logic [NODE_W-1:0]   cur_reg;
    logic                found_reg;
    logic [NODE_W-1:0]   other_reg;
    logic [WEIGHT_BITS-1:0] w_reg;

    logic                out_valid_reg;
    logic [NODE_W-1:0]   out_node_reg;
    logic [DIST_W-1:0]   out_dist_reg;
    logic                out_reach_reg;
    logic                out_err_reg;
    logic                out_last_reg;

    logic [NCNT_W-1:0]   n_live;
    logic                in_acc;
    logic [NODE_W-1:0]   in_a, in_b;
    logic [WEIGHT_BITS-1:0] in_w;
    logic                add_ok;

    logic                e_we;
    logic [EADDR_W-1:0]  e_raddr;
    logic [EDGE_W-1:0]   e_rdata;
    logic [NODE_W-1:0]   e_a, e_b;
    logic [WEIGHT_BITS-1:0] e_w;
    logic                e_bad;

    logic                d_we;
    logic [NODE_W-1:0]   d_waddr, d_raddr;
    logic [DIST_W:0]     d_wdata, d_rdata;
    logic [DIST_W-1:0]   d_dist;
    logic                d_settled;
    logic [DIST_W-1:0]   cand;
    logic                issue;
    logic                out_free;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_live = NCNT_W'(1);
        end
        else if (node_count_reg > NCNT_W'(MAX_NODES))
        begin
            n_live = NCNT_W'(MAX_NODES);
        end
        else
        begin
            n_live = node_count_reg;
        end
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_a          = s_axis_tdata[5:0];
    assign in_b          = s_axis_tdata[11:6];
    assign in_w          = s_axis_tdata[12 +: WEIGHT_BITS];
    assign add_ok        = (edge_count_reg < ECNT_W'(MAX_EDGES))
                           && ({1'b0, in_a} < n_live) && ({1'b0, in_b} < n_live);
    assign e_we          = in_acc && (s_axis_tuser == CMD_ADD) && add_ok;

    assign e_a   = e_rdata[EDGE_W-1 -: NODE_W];
    assign e_b   = e_rdata[WEIGHT_BITS +: NODE_W];
    assign e_w   = e_rdata[WEIGHT_BITS-1:0];
    assign e_bad = ({1'b0, e_a} >= n_live) || ({1'b0, e_b} >= n_live);
    assign d_dist    = d_rdata[DIST_W-1:0];
    assign d_settled = d_rdata[DIST_W];
    assign cand  = best_reg + DIST_W'(w_reg);
    assign out_free = !out_valid_reg || m_axis_tready;

    assign issue = (state_reg == ST_SCAN) ? (k_reg != edge_count_reg)
                                          : (i_reg != n_live);

    // The distance RAM holds the settled mark above the distance of each node.
    always_comb
    begin
        e_raddr = k_reg[EADDR_W-1:0];
        d_raddr = i_reg[NODE_W-1:0];
        if (state_reg == ST_RLX_EDGE)
        begin
            d_raddr = (e_a == cur_reg) ? e_b : e_a;
        end
        d_we    = 1'b0;
        d_waddr = i_reg[NODE_W-1:0];
        d_wdata = {1'b0, UNREACHED};
        if (state_reg == ST_INIT)
        begin
            d_we = 1'b1;
            if ((i_reg[NODE_W-1:0] == source_reg) && ({1'b0, source_reg} < n_live))
            begin
                d_wdata = '0;
            end
        end
        else if ((state_reg == ST_MIN) && !issue && !rd_v_reg && found_reg)
        begin
            d_we    = 1'b1;
            d_waddr = cur_reg;
            d_wdata = {1'b1, best_reg};
        end
        else if ((state_reg == ST_RLX_DIST) && (cand < d_dist))
        begin
            d_we    = 1'b1;
            d_waddr = other_reg;
            d_wdata = {d_settled, cand};
        end
    end

    spd_ram #(.W(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (edge_count_reg[EADDR_W-1:0]),
        .wdata ({in_a, in_b, in_w}),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    spd_ram #(.W(DIST_W + 1), .DEPTH(MAX_NODES)) u_dist_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (s_axis_tuser == CMD_SOLVE))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (i_reg == NCNT_W'(MAX_NODES - 1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue && !rd_v_reg)
                begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (!issue && !rd_v_reg)
                begin
                    state_next = found_reg ? ST_RLX_RD : ST_EMIT_RD;
                end
            end
            ST_RLX_RD:
            begin
                state_next = (k_reg == edge_count_reg) ? ST_MIN : ST_RLX_EDGE;
            end
            ST_RLX_EDGE:
            begin
                if (!e_bad && ((e_a == cur_reg) || (e_b == cur_reg)))
                begin
                    state_next = ST_RLX_DIST;
                end
                else
                begin
                    state_next = ST_RLX_RD;
                end
            end
            ST_RLX_DIST:
            begin
                state_next = ST_RLX_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    state_next = (i_reg + NCNT_W'(1) == n_live) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NCNT_W'(MAX_NODES);
            source_reg     <= '0;
            edge_count_reg <= '0;
            dropped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_v_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_NODE_COUNT:  node_count_reg <= cfg_data;
                    REG_SOURCE_NODE: source_reg     <= cfg_data[NODE_W-1:0];
                    default:         node_count_reg <= node_count_reg;
                endcase
            end

            if (in_acc && (s_axis_tuser == CMD_ADD))
            begin
                if (add_ok)
                begin
                    edge_count_reg <= edge_count_reg + ECNT_W'(1);
                end
                else
                begin
                    dropped_reg <= 1'b1;
                end
            end

            rd_v_reg <= ((state_reg == ST_SCAN) || (state_reg == ST_MIN)) && issue;

            if ((state_reg == ST_EMIT_LD) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (i_reg + NCNT_W'(1) == n_live)
                begin
                    edge_count_reg <= '0;
                    dropped_reg    <= 1'b0;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= i_reg[NODE_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                i_reg       <= '0;
                k_reg       <= '0;
                err_reg     <= dropped_reg;
            end
            ST_INIT:
            begin
                i_reg <= (i_reg == NCNT_W'(MAX_NODES - 1)) ? '0 : i_reg + NCNT_W'(1);
                best_reg  <= UNREACHED;
                found_reg <= 1'b0;
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    k_reg <= k_reg + ECNT_W'(1);
                end
                if (rd_v_reg && e_bad)
                begin
                    err_reg <= 1'b1;
                end
            end
            ST_MIN:
            begin
                if (issue)
                begin
                    i_reg <= i_reg + NCNT_W'(1);
                end
                if (rd_v_reg && !d_settled && (d_dist < best_reg))
                begin
                    best_reg  <= d_dist;
                    cur_reg   <= rd_idx_reg;
                    found_reg <= 1'b1;
                end
                if (!issue && !rd_v_reg)
                begin
                    i_reg <= '0;
                    k_reg <= '0;
                end
            end
            ST_RLX_RD:
            begin
                if (k_reg == edge_count_reg)
                begin
                    best_reg  <= UNREACHED;
                    found_reg <= 1'b0;
                end
            end
            ST_RLX_EDGE:
            begin
                other_reg <= (e_a == cur_reg) ? e_b : e_a;
                w_reg     <= e_w;
                if (e_bad || ((e_a != cur_reg) && (e_b != cur_reg)))
                begin
                    k_reg <= k_reg + ECNT_W'(1);
                end
            end
            ST_RLX_DIST:
            begin
                k_reg <= k_reg + ECNT_W'(1);
            end
            ST_EMIT_RD:
            begin
                best_reg <= best_reg;
            end
            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_node_reg  <= i_reg[NODE_W-1:0];
                    out_dist_reg  <= d_dist;
                    out_reach_reg <= (d_dist < UNREACHED);
                    out_err_reg   <= err_reg;
                    out_last_reg  <= (i_reg + NCNT_W'(1) == n_live);
                    i_reg         <= i_reg + NCNT_W'(1);
                end
            end
            default:
            begin
                i_reg <= '0;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_dist_reg, out_node_reg};
    assign m_axis_tuser  = {out_err_reg, out_reach_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule
